@@ rtl/mcg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcg_pkg
// shared types, constants and saturation helpers for the metronome click core
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int CD_W      = 32;
  localparam int QP_W      = 28;
  localparam int PERIOD_W  = QP_W + 2;
  localparam int BPB_W     = 5;
  localparam int DLOG_W    = 3;
  localparam int OSC_W     = 18;
  localparam int ENV_W     = 21;
  localparam int SMP_W     = 16;
  localparam int COEF_W    = 14;

  localparam int MCAND_W   = OSC_W;
  localparam int MPLIER_W  = 22;
  localparam int HI_W      = 21;
  localparam int LO_W      = MPLIER_W;
  localparam int DIG_CNT_W = 4;

  localparam logic [DIG_CNT_W-1:0] COEF_DIGITS = 4'd7;
  localparam logic [DIG_CNT_W-1:0] ENV_DIGITS  = 4'd11;

  localparam logic [BPB_W-1:0]  BPB_RESET  = 5'd4;
  localparam logic [DLOG_W-1:0] DLOG_RESET = 3'd2;

  localparam logic [ENV_W-1:0]  ENV_STEP    = 21'd105;
  localparam logic [ENV_W-1:0]  ENV_ONE     = 21'd1048576;
  localparam logic [OSC_W-1:0]  ONE_Q16     = 18'd65536;
  localparam logic [COEF_W-1:0] COEF_ACCENT = 14'd8211;
  localparam logic [COEF_W-1:0] COEF_CLICK  = 14'd4108;
  localparam logic [CD_W-1:0]   CD_MIN      = 32'h8000_0000;
  localparam logic [CD_W:0]     CD_TICK     = 33'd256;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_TOGGLE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_BEATS_PER_BAR = 1'b0,
    REG_DENOM_LOG2    = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEAT,
    ST_LOAD_C,
    ST_WAIT_C,
    ST_COS,
    ST_WAIT_S,
    ST_SIN,
    ST_WAIT_O,
    ST_OUT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [BPB_W-1:0]  beats_per_bar;
    logic [DLOG_W-1:0] denominator_log2;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [MCAND_W-1:0]   mcand;
    logic [MPLIER_W-1:0]  mplier;
    logic [DIG_CNT_W-1:0] ndig;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [HI_W-1:0] hi;
    logic [LO_W-1:0] lo;
  } mul_rsp_t;

  function automatic logic signed [OSC_W-1:0] sat_q216(input logic signed [OSC_W+1:0] v);
    logic signed [OSC_W-1:0] r;
    if (v > 20'sd131071) begin
      r = 18'sh1FFFF;
    end else if (v < -20'sd131072) begin
      r = 18'sh20000;
    end else begin
      r = v[OSC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] sat_q115(input logic signed [SMP_W+5:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mcg_in_if.sv @@
// ----------------------------------------------------------------------------
// mcg_in_if
// request channel into the metronome core: command and quarter-note period
// ----------------------------------------------------------------------------
`default_nettype none

interface mcg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [27:0] quarter_period;

  modport source (output valid, output cmd, output quarter_period, input ready);
  modport sink   (input valid, input cmd, input quarter_period, output ready);
endinterface

`default_nettype wire

@@ rtl/mcg_out_if.sv @@
// ----------------------------------------------------------------------------
// mcg_out_if
// result channel out of the metronome core: click sample and run status
// ----------------------------------------------------------------------------
`default_nettype none

interface mcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               is_playing;

  modport source (output valid, output sample_out, output is_playing, input ready);
  modport sink   (input valid, input sample_out, input is_playing, output ready);
endinterface

`default_nettype wire

@@ rtl/mcg_apb_regs.sv @@
// ----------------------------------------------------------------------------
// mcg_apb_regs
// apb register file: beats per bar and log2 of the time signature denominator
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_apb_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output mcg_pkg::cfg_t                     cfg
);

  logic [mcg_pkg::BPB_W-1:0]  bpb_r;
  logic [mcg_pkg::BPB_W-1:0]  bpb_nxt;
  logic [mcg_pkg::DLOG_W-1:0] dlog_r;
  logic [mcg_pkg::DLOG_W-1:0] dlog_nxt;
  logic                       wr_en;
  mcg_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = mcg_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    bpb_nxt  = bpb_r;
    dlog_nxt = dlog_r;
    if (wr_en) begin
      case (idx)
        mcg_pkg::REG_BEATS_PER_BAR: bpb_nxt  = pwdata[mcg_pkg::BPB_W-1:0];
        mcg_pkg::REG_DENOM_LOG2:    dlog_nxt = pwdata[mcg_pkg::DLOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mcg_pkg::REG_BEATS_PER_BAR:
        prdata = {{(mcg_pkg::APB_DATA_W-mcg_pkg::BPB_W){1'b0}}, bpb_r};
      mcg_pkg::REG_DENOM_LOG2:
        prdata = {{(mcg_pkg::APB_DATA_W-mcg_pkg::DLOG_W){1'b0}}, dlog_r};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpb_r  <= mcg_pkg::BPB_RESET;
      dlog_r <= mcg_pkg::DLOG_RESET;
    end else begin
      bpb_r  <= bpb_nxt;
      dlog_r <= dlog_nxt;
    end
  end

  assign cfg.beats_per_bar    = bpb_r;
  assign cfg.denominator_log2 = dlog_r;

endmodule

`default_nettype wire

@@ rtl/mcg_serial_mul.sv @@
// ----------------------------------------------------------------------------
// mcg_serial_mul
// radix-4 digit-serial signed by unsigned multiplier, lsb digit first
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_serial_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  mcg_pkg::mul_req_t req,
  output mcg_pkg::mul_rsp_t rsp
);

  logic                              busy_r;
  logic                              busy_nxt;
  logic [mcg_pkg::DIG_CNT_W-1:0]     cnt_r;
  logic [mcg_pkg::DIG_CNT_W-1:0]     cnt_nxt;
  logic signed [mcg_pkg::MCAND_W-1:0] mcand_r;
  logic signed [mcg_pkg::MCAND_W-1:0] mcand_nxt;
  logic [mcg_pkg::MPLIER_W-1:0]      mplier_r;
  logic [mcg_pkg::MPLIER_W-1:0]      mplier_nxt;
  logic signed [mcg_pkg::HI_W-1:0]   hi_r;
  logic signed [mcg_pkg::HI_W-1:0]   hi_nxt;
  logic [mcg_pkg::LO_W-1:0]          lo_r;
  logic [mcg_pkg::LO_W-1:0]          lo_nxt;
  logic signed [mcg_pkg::HI_W-1:0]   m_ext;
  logic signed [mcg_pkg::HI_W-1:0]   pp;
  logic signed [mcg_pkg::HI_W-1:0]   sum;
  logic                              last;

  assign m_ext = {{(mcg_pkg::HI_W-mcg_pkg::MCAND_W){mcand_r[mcg_pkg::MCAND_W-1]}}, mcand_r};
  assign last  = busy_r && (cnt_r == {{(mcg_pkg::DIG_CNT_W-1){1'b0}}, 1'b1});

  always_comb begin
    case (mplier_r[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = m_ext;
      2'd2:    pp = m_ext <<< 1;
      default: pp = m_ext + (m_ext <<< 1);
    endcase
  end

  assign sum = hi_r + pp;

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = req.ndig;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      hi_nxt     = '0;
      lo_nxt     = '0;
    end else if (busy_r) begin
      busy_nxt   = !last;
      cnt_nxt    = cnt_r - {{(mcg_pkg::DIG_CNT_W-1){1'b0}}, 1'b1};
      mplier_nxt = mplier_r >> 2;
      hi_nxt     = sum >>> 2;
      lo_nxt     = {sum[1:0], lo_r[mcg_pkg::LO_W-1:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

  // product is held in hi_r/lo_r from the cycle after done
  assign rsp.done = last;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

`default_nettype wire

@@ rtl/metronome_click_generator_core.sv @@
// ----------------------------------------------------------------------------
// metronome_click_generator_core
// per-sample metronome with an accented coupled-form sine click
// ----------------------------------------------------------------------------
// Each request carries one command; every request yields one result. Start,
// stop, toggle and ticks while stopped go from acceptance to the write state,
// a running tick after the click has decayed through the beat state first;
// the core then returns to idle, the only state that takes a request. A
// running tick with a live click passes the beat, load, cosine, sine and
// output states, waiting on the multiplier after each start, before the
// write: the three products of the oscillator step and the output scaling
// share one radix-4 digit-serial multiplier, 7 digits for each coefficient
// product and 11 for the envelope product. A new request is taken while the
// previous result still waits in the output register; a finished result waits
// in the core, with the input held off, until the output register is free.
`default_nettype none

module metronome_click_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  mcg_in_if.sink                            in_chan,
  mcg_out_if.source                         out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  mcg_pkg::cfg_t     cfg;
  mcg_pkg::mul_req_t mul_req;
  mcg_pkg::mul_rsp_t mul_rsp;
  mcg_pkg::state_t   state_r;
  mcg_pkg::state_t   state_nxt;
  mcg_pkg::cmd_t     cmd;

  logic                              running_r;
  logic                              running_nxt;
  logic signed [mcg_pkg::CD_W-1:0]   countdown_r;
  logic signed [mcg_pkg::CD_W-1:0]   countdown_nxt;
  logic [mcg_pkg::BPB_W-1:0]         beats_left_r;
  logic [mcg_pkg::BPB_W-1:0]         beats_left_nxt;
  logic signed [mcg_pkg::OSC_W-1:0]  cos_r;
  logic signed [mcg_pkg::OSC_W-1:0]  cos_nxt;
  logic signed [mcg_pkg::OSC_W-1:0]  sin_r;
  logic signed [mcg_pkg::OSC_W-1:0]  sin_nxt;
  logic                              accent_r;
  logic                              accent_nxt;
  logic [mcg_pkg::ENV_W-1:0]         env_r;
  logic [mcg_pkg::ENV_W-1:0]         env_nxt;
  logic [mcg_pkg::QP_W-1:0]          quarter_r;
  logic [mcg_pkg::QP_W-1:0]          quarter_nxt;
  logic signed [mcg_pkg::SMP_W-1:0]  res_sample_r;
  logic signed [mcg_pkg::SMP_W-1:0]  res_sample_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [mcg_pkg::SMP_W-1:0]  out_sample_r;
  logic signed [mcg_pkg::SMP_W-1:0]  out_sample_nxt;
  logic                              out_playing_r;
  logic                              out_playing_nxt;

  logic                              accept;
  logic                              out_free;
  logic                              out_load;
  logic                              fire;
  logic                              env_live;
  logic [mcg_pkg::CD_W:0]            cd_dec;
  logic signed [mcg_pkg::CD_W-1:0]   cd_dec_sat;
  logic [mcg_pkg::PERIOD_W-1:0]      period;
  logic [mcg_pkg::BPB_W-1:0]         bar_len;
  logic [mcg_pkg::BPB_W-1:0]         bl_base;
  logic [mcg_pkg::COEF_W-1:0]        coef;
  logic [34:0]                       cprod;
  logic signed [mcg_pkg::OSC_W:0]    cprod_rnd;
  logic signed [mcg_pkg::OSC_W-1:0]  cprod_sat;
  logic signed [mcg_pkg::OSC_W+1:0]  cos_sum;
  logic signed [mcg_pkg::OSC_W+1:0]  sin_sum;
  logic signed [mcg_pkg::OSC_W-1:0]  cos_new;
  logic signed [mcg_pkg::OSC_W-1:0]  sin_new;
  logic [mcg_pkg::HI_W+mcg_pkg::LO_W-1:0] sprod;
  logic signed [mcg_pkg::SMP_W+5:0]  smp_rnd;

  mcg_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcg_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign cmd      = mcg_pkg::cmd_t'(in_chan.cmd);
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // beat countdown and bar position
  assign cd_dec     = {countdown_r[mcg_pkg::CD_W-1], countdown_r} - mcg_pkg::CD_TICK;
  assign cd_dec_sat = (cd_dec[mcg_pkg::CD_W] != cd_dec[mcg_pkg::CD_W-1]) ?
                      mcg_pkg::CD_MIN : cd_dec[mcg_pkg::CD_W-1:0];
  assign fire       = countdown_r[mcg_pkg::CD_W-1] || (countdown_r == '0);
  assign period     = {quarter_r, 2'b00} >> cfg.denominator_log2;
  assign bar_len    = (cfg.beats_per_bar == '0) ? {{(mcg_pkg::BPB_W-1){1'b0}}, 1'b1} :
                      cfg.beats_per_bar;
  assign bl_base    = (beats_left_r == '0) ? bar_len : beats_left_r;
  assign env_live   = fire || (env_r != '0);
  assign coef       = accent_r ? mcg_pkg::COEF_ACCENT : mcg_pkg::COEF_CLICK;

  // coefficient product to q2.16 with rounding
  assign cprod     = {mul_rsp.hi, mul_rsp.lo[mcg_pkg::LO_W-1:8]};
  assign cprod_rnd = cprod[34:16] + {{mcg_pkg::OSC_W{1'b0}}, cprod[15]};
  assign cprod_sat = mcg_pkg::sat_q216({cprod_rnd[mcg_pkg::OSC_W], cprod_rnd});
  assign cos_sum   = {{2{cos_r[mcg_pkg::OSC_W-1]}}, cos_r}
                   - {{2{cprod_sat[mcg_pkg::OSC_W-1]}}, cprod_sat};
  assign sin_sum   = {{2{sin_r[mcg_pkg::OSC_W-1]}}, sin_r}
                   + {{2{cprod_sat[mcg_pkg::OSC_W-1]}}, cprod_sat};
  assign cos_new   = mcg_pkg::sat_q216(cos_sum);
  assign sin_new   = mcg_pkg::sat_q216(sin_sum);

  // sine times envelope to q1.15 with rounding
  assign sprod   = {mul_rsp.hi, mul_rsp.lo};
  assign smp_rnd = sprod[42:21] + {{(mcg_pkg::SMP_W+5){1'b0}}, sprod[20]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcg_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          if (cmd == mcg_pkg::CMD_TICK && running_r) begin
            state_nxt = mcg_pkg::ST_BEAT;
          end else begin
            state_nxt = mcg_pkg::ST_WRITE;
          end
        end
      end
      mcg_pkg::ST_BEAT:   state_nxt = env_live ? mcg_pkg::ST_LOAD_C : mcg_pkg::ST_WRITE;
      mcg_pkg::ST_LOAD_C: state_nxt = mcg_pkg::ST_WAIT_C;
      mcg_pkg::ST_WAIT_C: state_nxt = mul_rsp.done ? mcg_pkg::ST_COS : mcg_pkg::ST_WAIT_C;
      mcg_pkg::ST_COS:    state_nxt = mcg_pkg::ST_WAIT_S;
      mcg_pkg::ST_WAIT_S: state_nxt = mul_rsp.done ? mcg_pkg::ST_SIN : mcg_pkg::ST_WAIT_S;
      mcg_pkg::ST_SIN:    state_nxt = mcg_pkg::ST_WAIT_O;
      mcg_pkg::ST_WAIT_O: state_nxt = mul_rsp.done ? mcg_pkg::ST_OUT : mcg_pkg::ST_WAIT_O;
      mcg_pkg::ST_OUT:    state_nxt = mcg_pkg::ST_WRITE;
      mcg_pkg::ST_WRITE:  state_nxt = out_free ? mcg_pkg::ST_IDLE : mcg_pkg::ST_WRITE;
      default:            state_nxt = mcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready  = 1'b0;
    out_load       = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = sin_r;
    mul_req.mplier = {{(mcg_pkg::MPLIER_W-mcg_pkg::COEF_W){1'b0}}, coef};
    mul_req.ndig   = mcg_pkg::COEF_DIGITS;
    case (state_r)
      mcg_pkg::ST_IDLE: in_chan.ready = 1'b1;
      mcg_pkg::ST_LOAD_C: mul_req.start = 1'b1;
      mcg_pkg::ST_COS: begin
        mul_req.start = 1'b1;
        mul_req.mcand = cos_new;
      end
      mcg_pkg::ST_SIN: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = sin_new;
        mul_req.mplier = {{(mcg_pkg::MPLIER_W-mcg_pkg::ENV_W){1'b0}}, env_r};
        mul_req.ndig   = mcg_pkg::ENV_DIGITS;
      end
      mcg_pkg::ST_WRITE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    running_nxt     = running_r;
    countdown_nxt   = countdown_r;
    beats_left_nxt  = beats_left_r;
    cos_nxt         = cos_r;
    sin_nxt         = sin_r;
    accent_nxt      = accent_r;
    env_nxt         = env_r;
    quarter_nxt     = quarter_r;
    res_sample_nxt  = res_sample_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_sample_nxt  = out_sample_r;
    out_playing_nxt = out_playing_r;

    if (accept) begin
      quarter_nxt    = in_chan.quarter_period;
      res_sample_nxt = '0;
      case (cmd)
        mcg_pkg::CMD_START: begin
          if (!running_r) begin
            running_nxt    = 1'b1;
            countdown_nxt  = '0;
            beats_left_nxt = '0;
          end
        end
        mcg_pkg::CMD_STOP: running_nxt = 1'b0;
        mcg_pkg::CMD_TOGGLE: begin
          running_nxt = !running_r;
          if (!running_r) begin
            countdown_nxt  = '0;
            beats_left_nxt = '0;
          end
        end
        default: begin
          if (running_r) begin
            countdown_nxt = cd_dec_sat;
          end
        end
      endcase
    end

    case (state_r)
      mcg_pkg::ST_BEAT: begin
        if (fire) begin
          cos_nxt        = mcg_pkg::ONE_Q16;
          sin_nxt        = '0;
          env_nxt        = mcg_pkg::ENV_ONE;
          accent_nxt     = (beats_left_r == '0);
          beats_left_nxt = bl_base - {{(mcg_pkg::BPB_W-1){1'b0}}, 1'b1};
          countdown_nxt  = countdown_r
                         + {{(mcg_pkg::CD_W-mcg_pkg::PERIOD_W){1'b0}}, period};
        end
      end
      mcg_pkg::ST_COS: cos_nxt = cos_new;
      mcg_pkg::ST_SIN: sin_nxt = sin_new;
      mcg_pkg::ST_OUT: begin
        res_sample_nxt = mcg_pkg::sat_q115(smp_rnd);
        env_nxt        = (env_r > mcg_pkg::ENV_STEP) ? (env_r - mcg_pkg::ENV_STEP) : '0;
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_sample_nxt  = res_sample_r;
      out_playing_nxt = running_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mcg_pkg::ST_IDLE;
      running_r    <= 1'b0;
      countdown_r  <= '0;
      beats_left_r <= '0;
      cos_r        <= mcg_pkg::ONE_Q16;
      sin_r        <= '0;
      accent_r     <= 1'b1;
      env_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      countdown_r  <= countdown_nxt;
      beats_left_r <= beats_left_nxt;
      cos_r        <= cos_nxt;
      sin_r        <= sin_nxt;
      accent_r     <= accent_nxt;
      env_r        <= env_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quarter_r     <= quarter_nxt;
    res_sample_r  <= res_sample_nxt;
    out_sample_r  <= out_sample_nxt;
    out_playing_r <= out_playing_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.is_playing = out_playing_r;

`ifndef SYNTHESIS
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == mcg_pkg::ST_WAIT_C || state_r == mcg_pkg::ST_WAIT_S ||
                      state_r == mcg_pkg::ST_WAIT_O))
    else $error("multiplier finished outside a wait state");

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= mcg_pkg::ENV_ONE)
    else $error("envelope above unity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("request taken while previous one in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcg_pkg::ST_WRITE && out_free) |=>
      (out_valid_r && state_r == mcg_pkg::ST_IDLE))
    else $error("result not handed to output register");

  a_click_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcg_pkg::ST_BEAT && fire) |=>
      (env_r == mcg_pkg::ENV_ONE && sin_r == '0 && state_r == mcg_pkg::ST_LOAD_C))
    else $error("click did not restart oscillator");
`endif

endmodule

`default_nettype wire

@@ bench/metronome_click_generator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// metronome_click_generator_core_tb
// self-checking bench for the metronome click core
// ----------------------------------------------------------------------------
// Sends commands and sample ticks on the request channel, programs the time
// signature over APB between phases, and checks every result against an
// in-bench model of the beat countdown, bar counter, sine oscillator and
// envelope. A directed table runs first, then randomized phases over several
// time signatures (one with a long output stall), then a stretch of ticks in
// which neither side idles. Both channels stall at random elsewhere.
// ----------------------------------------------------------------------------
module metronome_click_generator_core_tb;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASE_ITEMS   = 85;
  localparam int CALM_TICKS    = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int OSC_UNITY     = 65536;
  localparam int ENV_FULL      = 1048576;
  localparam int ENV_DECREMENT = 105;
  localparam int ACCENT_COEF   = 8211;
  localparam int BEAT_COEF     = 4108;
  localparam longint CD_FLOOR  = -(64'sd1 <<< 31);

  typedef struct packed {
    mcg_pkg::cmd_t      cmd;
    logic [27:0]        quarter;
    logic               pinned;
    logic signed [15:0] sample;
    logic               playing;
  } drill_row_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               playing;
  } click_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [mcg_pkg::APB_ADDR_W-1:0] paddr;
  logic [mcg_pkg::APB_DATA_W-1:0] pwdata;
  logic [mcg_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  mcg_in_if  req_chan ();
  mcg_out_if res_chan ();

  metronome_click_generator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // model state
  logic [4:0] bar_beats_cfg;
  logic [2:0] denom_cfg;
  bit         run_on;
  longint     countdown;
  logic [4:0] beats_left;
  longint     osc_c;
  longint     osc_s;
  bit         accent;
  longint     env;

  click_result_t clicks_due[$];

  bit calm = 1'b0;
  int hold_requests = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int clicks_fired = 0;
  int accents_fired = 0;
  int silent_ticks = 0;

  drill_row_t drill_table [25] = '{
    '{mcg_pkg::CMD_TICK,   28'hFFFFFFF, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_STOP,   28'h0000000, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_START,  28'h0000000, 1'b1, 16'sd0,    1'b1},
    '{mcg_pkg::CMD_START,  28'hFFFFFFF, 1'b1, 16'sd0,    1'b1},
    '{mcg_pkg::CMD_TOGGLE, 28'h0000000, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TOGGLE, 28'h0000000, 1'b1, 16'sd0,    1'b1},
    '{mcg_pkg::CMD_TICK,   28'h0000100, 1'b1, 16'sd4106, 1'b1},
    '{mcg_pkg::CMD_TICK,   28'h0000000, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h00000FF, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h0000100, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h0000001, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h5555555, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_STOP,   28'hAAAAAAA, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h0000000, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_START,  28'h0000000, 1'b1, 16'sd0,    1'b1},
    '{mcg_pkg::CMD_TICK,   28'hFFFFFFF, 1'b1, 16'sd4106, 1'b1},
    '{mcg_pkg::CMD_TICK,   28'hFFFFFFF, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h0000000, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TOGGLE, 28'hFFFFFFF, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_STOP,   28'h0000000, 1'b1, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TOGGLE, 28'h0000000, 1'b1, 16'sd0,    1'b1},
    '{mcg_pkg::CMD_TICK,   28'h0000000, 1'b1, 16'sd4106, 1'b1},
    '{mcg_pkg::CMD_TICK,   28'h8000000, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h0000001, 1'b0, 16'sd0,    1'b0},
    '{mcg_pkg::CMD_TICK,   28'h7FFFFFF, 1'b0, 16'sd0,    1'b0}
  };

  int phase_bars   [8] = '{1, 16, 0, 31, 2, 7, 5, 16};
  int phase_denoms [8] = '{0, 4, 7, 5, 6, 1, 3, 2};

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint q16_product(input longint a, input longint b);
    return clamp((a * b + 32768) >>> 16, -131072, 131071);
  endfunction

  function automatic click_result_t metronome_step(input mcg_pkg::cmd_t cmd,
                                                   input logic [27:0] quarter);
    click_result_t r;
    longint        coef;
    longint        prod;
    r.sample = '0;
    if (cmd == mcg_pkg::CMD_START || (cmd == mcg_pkg::CMD_TOGGLE && !run_on)) begin
      if (!run_on) begin
        countdown  = 0;
        beats_left = '0;
      end
      run_on = 1'b1;
    end else if (cmd == mcg_pkg::CMD_STOP || cmd == mcg_pkg::CMD_TOGGLE) begin
      run_on = 1'b0;
    end else if (run_on) begin
      countdown = countdown - 256;
      if (countdown < CD_FLOOR) countdown = CD_FLOOR;
      if (countdown <= 0) begin
        osc_c  = OSC_UNITY;
        osc_s  = 0;
        env    = ENV_FULL;
        accent = (beats_left == 5'd0);
        if (accent) beats_left = (bar_beats_cfg == 5'd0) ? 5'd1 : bar_beats_cfg;
        beats_left = beats_left - 5'd1;
        countdown  = countdown + ((longint'(quarter) << 2) >> denom_cfg);
        clicks_fired++;
        if (accent) accents_fired++;
      end
      if (env > 0) begin
        coef     = accent ? ACCENT_COEF : BEAT_COEF;
        osc_c    = clamp(osc_c - q16_product(coef, osc_s), -131072, 131071);
        osc_s    = clamp(osc_s + q16_product(coef, osc_c), -131072, 131071);
        prod     = osc_s * env + (64'sd1 <<< 20);
        r.sample = 16'(clamp(prod >>> 21, -32768, 32767));
        env      = (env > ENV_DECREMENT) ? env - ENV_DECREMENT : 0;
      end else begin
        silent_ticks++;
      end
    end
    r.playing = run_on;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int index, input longint got,
                               input longint want);
    mismatches++;
    $display("mismatch on %s, result %0d: got %0d, expected %0d", what, index, got, want);
  endtask

  task automatic offer_request(input mcg_pkg::cmd_t cmd, input logic [27:0] quarter,
                               input bit pinned = 1'b0,
                               input logic signed [15:0] pinned_sample = '0,
                               input logic pinned_playing = 1'b0);
    click_result_t due;
    req_chan.valid          <= 1'b1;
    req_chan.cmd            <= cmd;
    req_chan.quarter_period <= quarter;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
    due = metronome_step(cmd, quarter);
    if (pinned) begin
      due.sample  = pinned_sample;
      due.playing = pinned_playing;
    end
    clicks_due.push_back(due);
    requests_sent++;
    if (!calm && $urandom_range(0, 99) < 20) begin
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic let_results_drain();
    req_chan.valid <= 1'b0;
    while (clicks_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input mcg_pkg::reg_idx_t idx, input int value);
    logic [31:0] mask;
    logic [31:0] written;
    int          byte_addr;
    mask      = (idx == mcg_pkg::REG_BEATS_PER_BAR) ? 32'h1F : 32'h7;
    written   = ($urandom & ~mask) | (32'(value) & mask);
    byte_addr = int'(idx) * 4;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= byte_addr[mcg_pkg::APB_ADDR_W-1:0];
    pwdata  <= written;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == mcg_pkg::REG_BEATS_PER_BAR) bar_beats_cfg = written[4:0];
    else denom_cfg = written[2:0];
    reg_writes++;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== (written & mask))
      note_mismatch("register read-back", int'(idx), prdata, written & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    mcg_pkg::cmd_t cmd;
    int            pick;
    logic [27:0]   quarter;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (run_on)
        cmd = pick < 90 ? mcg_pkg::CMD_TICK : pick < 93 ? mcg_pkg::CMD_START :
              pick < 97 ? mcg_pkg::CMD_STOP : mcg_pkg::CMD_TOGGLE;
      else
        cmd = pick < 40 ? mcg_pkg::CMD_TICK : pick < 70 ? mcg_pkg::CMD_START :
              pick < 75 ? mcg_pkg::CMD_STOP : mcg_pkg::CMD_TOGGLE;
      pick = $urandom_range(0, 99);
      if (pick < 55) quarter = 28'($urandom_range(0, 24 * 256));
      else if (pick < 85) quarter = 28'($urandom_range(0, 256 * 256));
      else quarter = 28'($urandom);
      offer_request(cmd, quarter);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT,
               clicks_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : result_monitor
    int            hold_left;
    int            holds_taken;
    click_result_t want;
    hold_left   = 0;
    holds_taken = 0;
    res_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
        results_seen++;
        if (clicks_due.size() == 0) begin
          note_mismatch("result with no request pending", results_seen,
                        res_chan.sample_out, 0);
        end else begin
          want = clicks_due.pop_front();
          if (res_chan.sample_out !== want.sample)
            note_mismatch("sample_out", results_seen, res_chan.sample_out, want.sample);
          if (res_chan.is_playing !== want.playing)
            note_mismatch("is_playing", results_seen, res_chan.is_playing, want.playing);
        end
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= calm || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  initial begin : stimulus
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_chan.valid          = 1'b0;
    req_chan.cmd            = mcg_pkg::CMD_TICK;
    req_chan.quarter_period = '0;
    bar_beats_cfg = 5'd4;
    denom_cfg     = 3'd2;
    run_on        = 1'b0;
    countdown     = 0;
    beats_left    = '0;
    osc_c         = OSC_UNITY;
    osc_s         = 0;
    accent        = 1'b1;
    env           = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill_table[i])
      offer_request(drill_table[i].cmd, drill_table[i].quarter, drill_table[i].pinned,
                    drill_table[i].sample, drill_table[i].playing);

    for (int p = 0; p < 9; p++) begin
      let_results_drain();
      program_reg(mcg_pkg::REG_BEATS_PER_BAR, p < 8 ? phase_bars[p] : $urandom_range(0, 31));
      program_reg(mcg_pkg::REG_DENOM_LOG2, p < 8 ? phase_denoms[p] : $urandom_range(0, 7));
      // output stall while requests keep coming
      if (p == 1) hold_requests <= hold_requests + 1;
      random_phase(PHASE_ITEMS);
    end

    // long period, neither side idles
    let_results_drain();
    program_reg(mcg_pkg::REG_BEATS_PER_BAR, 1);
    program_reg(mcg_pkg::REG_DENOM_LOG2, 0);
    calm <= 1'b1;
    offer_request(mcg_pkg::CMD_STOP, '0);
    offer_request(mcg_pkg::CMD_START, 28'hFFFFFFF);
    repeat (CALM_TICKS) offer_request(mcg_pkg::CMD_TICK, {1'b1, 27'($urandom)});
    calm <= 1'b0;

    let_results_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d register writes, one %0d-cycle stall",
             requests_sent, results_seen, reg_writes, HOLD_CYCLES);
    $display("clicks fired %0d (accents %0d), running ticks with the click decayed %0d",
             clicks_fired, accents_fired, silent_ticks);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mcg_pkg.sv
rtl/mcg_in_if.sv
rtl/mcg_out_if.sv
rtl/mcg_apb_regs.sv
rtl/mcg_serial_mul.sv
rtl/metronome_click_generator_core.sv
bench/metronome_click_generator_core_tb.sv
